// ----- design/pte2d_pkg.sv -----
// shared types, constants and latency helpers for the point-edge impact test
// no dependencies
package pte2d_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int TIME_BITS_DEF = 32;
  localparam int LIMB_W = 32;

  // one request: six packed positions and the endpoint flag
  typedef struct packed {
    logic [63:0] p_start;
    logic [63:0] p_end;
    logic [63:0] a_start;
    logic [63:0] a_end;
    logic [63:0] b_start;
    logic [63:0] b_end;
    logic        point_is_endpoint;
  } req_t;

  // one result
  typedef struct packed {
    logic        hit;
    logic [31:0] impact_time;
  } res_t;

  // cycles through one limb-serial multiplier
  function automatic int mul_lat(int aw, int bw);
    return ((aw + LIMB_W - 1) / LIMB_W) * ((bw + LIMB_W - 1) / LIMB_W) + 2;
  endfunction

endpackage

// ----- design/pte2d_delay.sv -----
// fixed-length register delay line for side data
// depends on nothing
module pte2d_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] pipe [N];

  // shift line
  always_ff @(posedge clk) begin
    pipe[0] <= d;
    for (int i = 1; i < N; i++) begin
      pipe[i] <= pipe[i-1];
    end
  end

  assign q = pipe[N-1];

endmodule

// ----- design/pte2d_mul.sv -----
// pipelined signed multiplier, one 32x32 limb product per stage
// depends on pte2d_pkg
module pte2d_mul #(
  parameter int AW = 34,
  parameter int BW = 34
) (
  input  logic                    clk,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] p
);
  import pte2d_pkg::*;

  localparam int NA  = (AW + LIMB_W - 1) / LIMB_W;
  localparam int NB  = (BW + LIMB_W - 1) / LIMB_W;
  localparam int NS  = NA * NB;
  localparam int PW  = AW + BW;
  localparam int ACW = (NA + NB) * LIMB_W;
  localparam int PPW = 2 * LIMB_W;

  logic [AW-1:0]        amag;
  logic [BW-1:0]        bmag;
  logic [NA*LIMB_W-1:0] am  [NS+1];
  logic [NB*LIMB_W-1:0] bm  [NS+1];
  logic [ACW-1:0]       acc [NS+1];
  logic                 ng  [NS+1];

  assign amag = a[AW-1] ? (~a + 1'b1) : a;
  assign bmag = b[BW-1] ? (~b + 1'b1) : b;

  // magnitudes and result sign
  always_ff @(posedge clk) begin
    am[0]  <= (NA*LIMB_W)'(amag);
    bm[0]  <= (NB*LIMB_W)'(bmag);
    ng[0]  <= a[AW-1] ^ b[BW-1];
    acc[0] <= '0;
  end

  // one partial product per stage
  for (genvar s = 0; s < NS; s++) begin : g_pp
    localparam int I = s / NB;
    localparam int J = s % NB;
    logic [PPW-1:0] pp;
    assign pp = PPW'(am[s][I*LIMB_W +: LIMB_W]) * PPW'(bm[s][J*LIMB_W +: LIMB_W]);
    always_ff @(posedge clk) begin
      am[s+1]  <= am[s];
      bm[s+1]  <= bm[s];
      ng[s+1]  <= ng[s];
      acc[s+1] <= acc[s] + (ACW'(pp) << (LIMB_W * (I + J)));
    end
  end

  // apply sign
  always_ff @(posedge clk) begin
    p <= ng[NS] ? -$signed(acc[NS][PW-1:0]) : $signed(acc[NS][PW-1:0]);
  end

endmodule

// ----- design/pte2d_sqrt.sv -----
// pipelined integer square root, one root bit per stage
// depends on nothing
module pte2d_sqrt #(
  parameter int IW = 142
) (
  input  logic            clk,
  input  logic [IW-1:0]   x,
  output logic [IW/2-1:0] r
);

  localparam int RW   = IW / 2;
  localparam int REMW = RW + 3;

  logic [IW-1:0]   rad  [RW+1];
  logic [REMW-1:0] rem  [RW+1];
  logic [RW-1:0]   root [RW+1];

  // load radicand
  always_ff @(posedge clk) begin
    rad[0]  <= x;
    rem[0]  <= '0;
    root[0] <= '0;
  end

  // restoring digit step
  for (genvar s = 0; s < RW; s++) begin : g_st
    logic [REMW-1:0] t;
    logic [REMW-1:0] tr;
    assign t  = REMW'({rem[s], rad[s][IW-1 -: 2]});
    assign tr = REMW'({root[s], 2'b01});
    always_ff @(posedge clk) begin
      rad[s+1] <= rad[s] << 2;
      if (t >= tr) begin
        rem[s+1]  <= t - tr;
        root[s+1] <= {root[s][RW-2:0], 1'b1};
      end else begin
        rem[s+1]  <= t;
        root[s+1] <= {root[s][RW-2:0], 1'b0};
      end
    end
  end

  assign r = root[RW];

endmodule

// ----- design/pte2d_div.sv -----
// pipelined fraction divider, floor(n * 2^QW / d) for n < d, one bit per stage
// depends on nothing
module pte2d_div #(
  parameter int NW = 71,
  parameter int QW = 32
) (
  input  logic          clk,
  input  logic [NW-1:0] n,
  input  logic [NW-1:0] d,
  output logic [QW-1:0] q
);

  logic [NW-1:0] rem [QW+1];
  logic [NW-1:0] dv  [QW+1];
  logic [QW-1:0] qt  [QW+1];

  // load operands
  always_ff @(posedge clk) begin
    rem[0] <= n;
    dv[0]  <= d;
    qt[0]  <= '0;
  end

  // restoring step
  for (genvar s = 0; s < QW; s++) begin : g_st
    logic [NW:0] t;
    assign t = {rem[s], 1'b0};
    always_ff @(posedge clk) begin
      dv[s+1] <= dv[s];
      if (t >= {1'b0, dv[s]}) begin
        rem[s+1] <= NW'(t - {1'b0, dv[s]});
        qt[s+1]  <= {qt[s][QW-2:0], 1'b1};
      end else begin
        rem[s+1] <= NW'(t);
        qt[s+1]  <= {qt[s][QW-2:0], 1'b0};
      end
    end
  end

  assign q = qt[QW];

endmodule

// ----- design/point_edge_time_of_impact_2d.sv -----
// Point-edge time of impact in 2D, fully pipelined.
// The 71-stage square root and the 32-stage divider make up most of the pipeline.
// Throughput: one request per cycle; busy is never raised and done is high for one cycle per result.
// Reset clears the valid pipeline only; data registers are not reset.
module point_edge_time_of_impact_2d #(
  parameter int COORD_BITS = pte2d_pkg::COORD_BITS_DEF,
  parameter int TIME_BITS  = pte2d_pkg::TIME_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  pte2d_pkg::req_t req,
  output logic            done,
  output pte2d_pkg::res_t res
);
  import pte2d_pkg::*;

  localparam int CW  = COORD_BITS;
  localparam int DW  = CW + 2;
  localparam int KW  = 2 * CW + 6;
  localparam int DSW = 4 * CW + 14;
  localparam int RW  = DSW / 2;
  localparam int NSW = 2 * CW + 9;
  localparam int NW  = 2 * CW + 7;
  localparam int PW3 = DW + NW + 1;
  localparam int EW  = PW3 + 1;
  localparam int TB  = TIME_BITS;
  localparam int L1  = mul_lat(DW, DW);
  localparam int L2  = mul_lat(KW, KW);
  localparam int L3  = RW + 1;
  localparam int L4  = mul_lat(DW, NW + 1);
  localparam int L5  = TB + 1;
  localparam int TN  = L1 + L2 + L3 + 3;
  localparam int TS  = TN + L4 + 2;
  localparam int TOUT = TS + L5 + 1;

  logic [63:0]          fld [6];
  logic signed [CW-1:0] crd [6][2];
  logic signed [DW-1:0] cx  [6][2];

  logic signed [DW-1:0] u0 [2];
  logic signed [DW-1:0] w0 [2];
  logic signed [DW-1:0] du [2];
  logic signed [DW-1:0] dw [2];
  logic signed [DW-1:0] e0 [2];
  logic signed [DW-1:0] de [2];
  logic                 ep1;

  logic signed [DW-1:0]   ma1 [8];
  logic signed [DW-1:0]   mb1 [8];
  logic signed [2*DW-1:0] mp1 [8];

  logic signed [KW-1:0]   c0, c1, c2;
  logic signed [2*KW-1:0] sq, pc;
  logic                   ep_d, c2z_d;
  logic signed [DSW-1:0]  disc;
  logic                   bad;
  logic [DSW-1:0]         sqin;
  logic [RW-1:0]          root;
  logic                   bad_n;
  logic [2*KW-1:0]        c12_n;

  logic signed [KW-1:0]  c1n, c2n;
  logic signed [NSW-1:0] rs, c1e, dd, n0c, n1c;
  logic                  ok0c, ok1c;
  logic [NW-1:0]         nr0, nr1, dr;
  logic                  okr0, okr1;

  logic [8*DW-1:0]       sd_n;
  logic signed [DW-1:0]  e0n [2];
  logic signed [DW-1:0]  den [2];
  logic signed [DW-1:0]  w0n [2];
  logic signed [DW-1:0]  dwn [2];
  logic signed [NW:0]    dsg;
  logic signed [NW:0]    nsg [2];
  logic signed [PW3-1:0] pe [2];
  logic signed [PW3-1:0] pf [2];
  logic signed [PW3-1:0] qe [2][2];
  logic signed [PW3-1:0] qf [2][2];
  logic [3*NW+1:0]       side_e;

  logic signed [EW-1:0] ee [2][2];
  logic signed [EW-1:0] ff [2][2];
  logic [NW-1:0]        n0e, n1e, de_e;
  logic                 ok0e, ok1e;
  logic                 sok [2];

  logic          hit_s;
  logic [NW-1:0] nsel, dsel;
  logic [TB-1:0] qt;
  logic          hit_q;
  logic          vld [TOUT];

  // s-parameter range test: s = f/e in [0,1]
  function automatic logic in_range(logic signed [EW-1:0] e, logic signed [EW-1:0] f);
    if (e < 0) begin
      return (f >= e) && (f <= 0);
    end
    return (f >= 0) && (f <= e);
  endfunction

  // coordinate unpacking, x high half and y low half
  assign fld[0] = req.p_start;
  assign fld[1] = req.p_end;
  assign fld[2] = req.a_start;
  assign fld[3] = req.a_end;
  assign fld[4] = req.b_start;
  assign fld[5] = req.b_end;

  for (genvar f = 0; f < 6; f++) begin : g_fld
    for (genvar ax = 0; ax < 2; ax++) begin : g_ax
      assign crd[f][ax] = fld[f][(ax == 0 ? 32 : 0) +: CW];
      assign cx[f][ax]  = DW'(crd[f][ax]);
    end
  end

  // relative positions and motions
  always_ff @(posedge clk) begin
    for (int ax = 0; ax < 2; ax++) begin
      u0[ax] <= cx[2][ax] - cx[0][ax];
      w0[ax] <= cx[4][ax] - cx[0][ax];
      du[ax] <= (cx[3][ax] - cx[2][ax]) - (cx[1][ax] - cx[0][ax]);
      dw[ax] <= (cx[5][ax] - cx[4][ax]) - (cx[1][ax] - cx[0][ax]);
      e0[ax] <= cx[4][ax] - cx[2][ax];
      de[ax] <= (cx[5][ax] - cx[4][ax]) - (cx[3][ax] - cx[2][ax]);
    end
    ep1 <= req.point_is_endpoint;
  end

  // cross product terms of the quadratic
  assign ma1[0] = u0[0]; assign mb1[0] = w0[1];
  assign ma1[1] = u0[1]; assign mb1[1] = w0[0];
  assign ma1[2] = u0[0]; assign mb1[2] = dw[1];
  assign ma1[3] = u0[1]; assign mb1[3] = dw[0];
  assign ma1[4] = du[0]; assign mb1[4] = w0[1];
  assign ma1[5] = du[1]; assign mb1[5] = w0[0];
  assign ma1[6] = du[0]; assign mb1[6] = dw[1];
  assign ma1[7] = du[1]; assign mb1[7] = dw[0];

  for (genvar m = 0; m < 8; m++) begin : g_m1
    pte2d_mul #(.AW(DW), .BW(DW)) u_mul (
      .clk(clk), .a(ma1[m]), .b(mb1[m]), .p(mp1[m])
    );
  end

  // quadratic coefficients
  always_ff @(posedge clk) begin
    c0 <= KW'(mp1[0]) - KW'(mp1[1]);
    c1 <= KW'(mp1[2]) - KW'(mp1[3]) + KW'(mp1[4]) - KW'(mp1[5]);
    c2 <= KW'(mp1[6]) - KW'(mp1[7]);
  end

  pte2d_mul #(.AW(KW), .BW(KW)) u_sq (.clk(clk), .a(c1), .b(c1), .p(sq));
  pte2d_mul #(.AW(KW), .BW(KW)) u_pc (.clk(clk), .a(c2), .b(c0), .p(pc));

  pte2d_delay #(.W(1), .N(L1 + L2 + 1)) u_dep (.clk(clk), .d(ep1), .q(ep_d));
  pte2d_delay #(.W(1), .N(L2)) u_dc2z (.clk(clk), .d(c2 == '0), .q(c2z_d));
  pte2d_delay #(.W(2*KW), .N(L2 + 1 + L3)) u_dc12 (
    .clk(clk), .d({c1, c2}), .q(c12_n)
  );

  // discriminant and early rejection
  always_ff @(posedge clk) begin
    disc <= DSW'(sq) - (DSW'(pc) <<< 2);
    bad  <= ep_d | c2z_d | ((DSW'(sq) - (DSW'(pc) <<< 2)) < 0);
  end

  assign sqin = disc[DSW-1] ? '0 : disc;

  pte2d_sqrt #(.IW(DSW)) u_sqrt (.clk(clk), .x(sqin), .r(root));
  pte2d_delay #(.W(1), .N(L3)) u_dbad (.clk(clk), .d(bad), .q(bad_n));

  // both roots as fractions over a positive denominator
  assign c1n = c12_n[2*KW-1:KW];
  assign c2n = c12_n[KW-1:0];

  always_comb begin
    rs  = NSW'($signed({1'b0, root}));
    c1e = NSW'(c1n);
    dd  = NSW'(c2n) <<< 1;
    n0c = rs - c1e;
    n1c = -(c1e + rs);
    if (dd < 0) begin
      n0c = -n0c;
      n1c = -n1c;
      dd  = -dd;
    end
    ok0c = !bad_n && (n0c > 0) && (n0c < dd);
    ok1c = !bad_n && (n1c > 0) && (n1c < dd);
  end

  always_ff @(posedge clk) begin
    nr0  <= n0c[NW-1:0];
    nr1  <= n1c[NW-1:0];
    dr   <= dd[NW-1:0];
    okr0 <= ok0c;
    okr1 <= ok1c;
  end

  // edge and offset terms carried to the root stage
  pte2d_delay #(.W(8*DW), .N(TN)) u_dsd (
    .clk(clk),
    .d({e0[0], e0[1], de[0], de[1], w0[0], w0[1], dw[0], dw[1]}),
    .q(sd_n)
  );

  assign e0n[0] = sd_n[8*DW-1 -: DW];
  assign e0n[1] = sd_n[7*DW-1 -: DW];
  assign den[0] = sd_n[6*DW-1 -: DW];
  assign den[1] = sd_n[5*DW-1 -: DW];
  assign w0n[0] = sd_n[4*DW-1 -: DW];
  assign w0n[1] = sd_n[3*DW-1 -: DW];
  assign dwn[0] = sd_n[2*DW-1 -: DW];
  assign dwn[1] = sd_n[DW-1 -: DW];
  assign dsg    = $signed({1'b0, dr});
  assign nsg[0] = $signed({1'b0, nr0});
  assign nsg[1] = $signed({1'b0, nr1});

  // s numerator and denominator products per axis and root
  for (genvar ax = 0; ax < 2; ax++) begin : g_sax
    pte2d_mul #(.AW(DW), .BW(NW + 1)) u_pe (.clk(clk), .a(e0n[ax]), .b(dsg), .p(pe[ax]));
    pte2d_mul #(.AW(DW), .BW(NW + 1)) u_pf (.clk(clk), .a(w0n[ax]), .b(dsg), .p(pf[ax]));
    for (genvar k = 0; k < 2; k++) begin : g_k
      pte2d_mul #(.AW(DW), .BW(NW + 1)) u_qe (
        .clk(clk), .a(den[ax]), .b(nsg[k]), .p(qe[k][ax])
      );
      pte2d_mul #(.AW(DW), .BW(NW + 1)) u_qf (
        .clk(clk), .a(dwn[ax]), .b(nsg[k]), .p(qf[k][ax])
      );
    end
  end

  pte2d_delay #(.W(3*NW + 2), .N(L4 + 1)) u_dside (
    .clk(clk), .d({nr0, nr1, dr, okr0, okr1}), .q(side_e)
  );

  always_ff @(posedge clk) begin
    for (int k = 0; k < 2; k++) begin
      for (int ax = 0; ax < 2; ax++) begin
        ee[k][ax] <= EW'(pe[ax]) + EW'(qe[k][ax]);
        ff[k][ax] <= EW'(pf[ax]) + EW'(qf[k][ax]);
      end
    end
  end

  assign n0e  = side_e[3*NW+1 -: NW];
  assign n1e  = side_e[2*NW+1 -: NW];
  assign de_e = side_e[NW+1 -: NW];
  assign ok0e = side_e[1];
  assign ok1e = side_e[0];

  // s test on x, falling back to y when the x difference is zero
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      priority if (ee[k][0] != 0) begin
        sok[k] = in_range(ee[k][0], ff[k][0]);
      end else if (ee[k][1] != 0) begin
        sok[k] = in_range(ee[k][1], ff[k][1]);
      end else begin
        sok[k] = 1'b0;
      end
    end
  end

  // root 0 wins over root 1 when both are accepted
  always_ff @(posedge clk) begin
    hit_s <= (ok0e & sok[0]) | (ok1e & sok[1]);
    nsel  <= (ok0e & sok[0]) ? n0e : n1e;
    dsel  <= de_e;
  end

  pte2d_div #(.NW(NW), .QW(TB)) u_div (.clk(clk), .n(nsel), .d(dsel), .q(qt));
  pte2d_delay #(.W(1), .N(L5)) u_dhit (.clk(clk), .d(hit_s), .q(hit_q));

  // valid pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TOUT; i++) begin
        vld[i] <= 1'b0;
      end
      done <= 1'b0;
    end else begin
      vld[0] <= start;
      for (int i = 1; i < TOUT; i++) begin
        vld[i] <= vld[i-1];
      end
      done <= vld[TOUT-1];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    res.hit         <= hit_q;
    res.impact_time <= hit_q ? 32'(qt) : '0;
  end

  assign busy = 1'b0;

  // every request yields one result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##(TOUT + 1) done)
    else $error("result strobe missing after request");

  // endpoint requests never hit
  a_endpoint: assert property (@(posedge clk) disable iff (rst)
    (start && req.point_is_endpoint) |-> ##(TOUT + 1) !res.hit)
    else $error("endpoint request reported a hit");

  // no-hit results carry zero time
  a_zero_time: assert property (@(posedge clk) disable iff (rst)
    (done && !res.hit) |-> (res.impact_time == '0))
    else $error("nonzero time without hit");

endmodule

// ----- test/tb_point_edge_time_of_impact_2d.sv -----
// self-checking testbench for point_edge_time_of_impact_2d
// depends on pte2d_pkg and the block; computes expected impacts with wide integers

// expected impact tracking and comparison
class impact_scoreboard;
  typedef logic signed [255:0] wide_t;

  pte2d_pkg::res_t pending[$];
  int mismatches;

  function new();
    mismatches = 0;
  endfunction

  // signed Q16.16 coordinate from one half of a packed position
  function wide_t coord(logic [63:0] v, bit hi);
    logic signed [31:0] h;
    h = hi ? v[63:32] : v[31:0];
    return wide_t'(h);
  endfunction

  function wide_t cross2(wide_t x1, wide_t y1, wide_t x2, wide_t y2);
    return x1 * y2 - y1 * x2;
  endfunction

  function wide_t isqrt(wide_t d);
    wide_t r, c;
    r = 0;
    for (int b = 72; b >= 0; b--) begin
      c = r | (wide_t'(1) <<< b);
      if (c * c <= d) r = c;
    end
    return r;
  endfunction

  // segment parameter test along one axis; returns 0 when the axis difference vanishes
  function bit axis_test(wide_t n, wide_t d, wide_t e0, wide_t de, wide_t f0, wide_t df,
                         output bit ok);
    wide_t e, f;
    e = e0 * d + n * de;
    f = f0 * d + n * df;
    ok = 0;
    if (e == 0) return 0;
    if (e < 0) ok = (f >= e) && (f <= 0);
    else ok = (f >= 0) && (f <= e);
    return 1;
  endfunction

  function pte2d_pkg::res_t impact(pte2d_pkg::req_t q);
    pte2d_pkg::res_t o;
    wide_t px, py, ax, ay, bx, by, dpx, dpy, dax, day, dbx, dby;
    wide_t c0, c1, c2, disc, r, n, d, tq;
    bit ok;
    o = '0;
    if (q.point_is_endpoint) return o;
    px = coord(q.p_start, 1); py = coord(q.p_start, 0);
    ax = coord(q.a_start, 1); ay = coord(q.a_start, 0);
    bx = coord(q.b_start, 1); by = coord(q.b_start, 0);
    dpx = coord(q.p_end, 1) - px; dpy = coord(q.p_end, 0) - py;
    dax = coord(q.a_end, 1) - ax; day = coord(q.a_end, 0) - ay;
    dbx = coord(q.b_end, 1) - bx; dby = coord(q.b_end, 0) - by;
    c0 = cross2(ax - px, ay - py, bx - px, by - py);
    c1 = cross2(ax - px, ay - py, dbx - dpx, dby - dpy)
       + cross2(dax - dpx, day - dpy, bx - px, by - py);
    c2 = cross2(dax - dpx, day - dpy, dbx - dpx, dby - dpy);
    if (c2 == 0) return o;
    disc = c1 * c1 - 4 * c2 * c0;
    if (disc < 0) return o;
    r = isqrt(disc);
    for (int k = 0; k < 2; k++) begin
      n = (k == 0) ? r - c1 : -(c1 + r);
      d = 2 * c2;
      if (d < 0) begin
        n = -n;
        d = -d;
      end
      if (n <= 0 || n >= d) continue;
      if (!axis_test(n, d, bx - ax, dbx - dax, bx - px, dbx - dpx, ok))
        if (!axis_test(n, d, by - ay, dby - day, by - py, dby - dpy, ok))
          continue;
      if (ok) begin
        tq = (n <<< 32) / d;
        o.hit = 1'b1;
        o.impact_time = tq[31:0];
        return o;
      end
    end
    return o;
  endfunction

  function void note_request(pte2d_pkg::req_t q);
    pending = {pending, impact(q)};
  endfunction

  function void check_result(pte2d_pkg::res_t got);
    pte2d_pkg::res_t want;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result hit=%0b time=%h", got.hit, got.impact_time);
      return;
    end
    want = pending.pop_front();
    if (got.hit !== want.hit || got.impact_time !== want.impact_time) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected hit=%0b time=%h, got hit=%0b time=%h",
                 want.hit, want.impact_time, got.hit, got.impact_time);
    end
  endfunction
endclass

module tb_point_edge_time_of_impact_2d;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 136;
  localparam int IDLE_LIMIT = 4000;
  localparam logic [31:0] ONE = 32'h0001_0000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  pte2d_pkg::req_t req = '0;
  pte2d_pkg::res_t res;

  impact_scoreboard sb = new();
  int idle_cycles = 0;

  point_edge_time_of_impact_2d dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req(req), .done(done), .res(res)
  );

  always #5 clk = ~clk;

  // note accepted requests, check results, watch for a stuck block
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_request(req);
      if (done) sb.check_result(res);
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic logic [63:0] pos(logic [31:0] x, logic [31:0] y);
    return {x, y};
  endfunction

  // small coordinate within +-4.0, sometimes on the integer grid
  function automatic logic [31:0] near();
    logic [31:0] v;
    v = $urandom_range(0, 8 * ONE) - 4 * ONE;
    if ($urandom_range(0, 3) == 0) v[15:0] = '0;
    return v;
  endfunction

  function automatic pte2d_pkg::req_t rand_request();
    pte2d_pkg::req_t q;
    if ($urandom_range(0, 4) == 0) begin
      q = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
           $urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
           1'($urandom())};
    end else begin
      q.p_start = pos(near(), near());
      q.p_end   = pos(near(), near());
      q.a_start = pos(near(), near());
      q.a_end   = pos(near(), near());
      q.b_start = pos(near(), near());
      q.b_end   = pos(near(), near());
      // vertical segments force the y fallback for s
      if ($urandom_range(0, 7) == 0) begin
        q.b_start[63:32] = q.a_start[63:32];
        q.b_end[63:32] = q.a_end[63:32];
      end
      q.point_is_endpoint = ($urandom_range(0, 15) == 0);
    end
    return q;
  endfunction

  // hold one request until accepted; start stays high for the next one
  task automatic send(pte2d_pkg::req_t q);
    start <= 1'b1;
    req <= q;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic gap(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  pte2d_pkg::req_t dir[$];
  pte2d_pkg::req_t q;

  // append one directed request
  function automatic void add_dir(pte2d_pkg::req_t v);
    dir = {dir, v};
  endfunction

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // rotating segment crossed by a moving point
    q.p_start = pos(0, -ONE);       q.p_end = pos(0, ONE);
    q.a_start = pos(-ONE, 0);       q.a_end = pos(-ONE, ONE);
    q.b_start = pos(ONE, 0);        q.b_end = pos(ONE, -ONE);
    q.point_is_endpoint = 1'b0;
    add_dir(q);
    q.point_is_endpoint = 1'b1;     // endpoint point
    add_dir(q);
    // everything static: zero leading coefficient
    add_dir({pos(0, ONE), pos(0, ONE), pos(-ONE, 0), pos(-ONE, 0),
             pos(ONE, 0), pos(ONE, 0), 1'b0});
    // point far away from a rotating segment: negative discriminant likely
    add_dir({pos(9 * ONE, 9 * ONE), pos(9 * ONE, 9 * ONE), pos(-ONE, 0), pos(0, -ONE),
             pos(ONE, 0), pos(0, ONE), 1'b0});
    // degenerate segment, A equal to B
    add_dir({pos(0, -ONE), pos(ONE, ONE), pos(0, 0), pos(ONE, 0),
             pos(0, 0), pos(ONE, 0), 1'b0});
    // point starts on the segment: root at the start boundary
    add_dir({pos(0, 0), pos(ONE, 2 * ONE), pos(-ONE, 0), pos(-ONE, ONE),
             pos(ONE, 0), pos(ONE, -ONE), 1'b0});
    // point ends on the segment: root at the end boundary
    add_dir({pos(0, -ONE), pos(0, 0), pos(-ONE, 0), pos(-ONE, 0),
             pos(ONE, ONE), pos(ONE, 0), 1'b0});
    // segment vertical at the start only, so s still comes from x
    add_dir({pos(-ONE, 0), pos(ONE, 0), pos(0, -ONE), pos(ONE, -ONE),
             pos(0, ONE), pos(-ONE, ONE), 1'b0});
    // s out of range on x
    add_dir({pos(5 * ONE, -ONE), pos(5 * ONE, ONE), pos(-ONE, 0), pos(-ONE, ONE),
             pos(ONE, 0), pos(ONE, -ONE), 1'b0});
    // field extremes
    add_dir({{6{64'h0}}, 1'b0});
    add_dir({{6{64'hFFFF_FFFF_FFFF_FFFF}}, 1'b1});
    add_dir({{6{64'hFFFF_FFFF_FFFF_FFFF}}, 1'b0});
    add_dir({pos(32'h8000_0000, 32'h7FFF_FFFF), pos(32'h7FFF_FFFF, 32'h8000_0000),
             pos(32'h8000_0000, 32'h8000_0000), pos(32'h7FFF_FFFF, 32'h7FFF_FFFF),
             pos(32'h7FFF_FFFF, 32'h8000_0000), pos(32'h8000_0000, 32'h7FFF_FFFF),
             1'b0});
    add_dir({pos(32'h7FFF_FFFF, 0), pos(32'h8000_0000, 0), pos(0, 32'h8000_0000),
             pos(0, 32'h8000_0000), pos(0, 32'h7FFF_FFFF), pos(0, 32'h7FFF_FFFF), 1'b0});
    foreach (dir[i]) send(dir[i]);

    // random requests in bursts with gaps
    for (int n = 0; n < 1300; ) begin
      int burst;
      burst = $urandom_range(1, 40);
      for (int j = 0; j < burst && n < 1300; j++, n++) send(rand_request());
      if (n >= 650 && n < 650 + burst) begin
        // drain the pipeline completely once
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
      end else if ($urandom_range(0, 2) != 0) begin
        gap($urandom_range(1, 12));
      end
    end
    start <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
design/pte2d_pkg.sv
design/pte2d_delay.sv
design/pte2d_mul.sv
design/pte2d_sqrt.sv
design/pte2d_div.sv
design/point_edge_time_of_impact_2d.sv
test/tb_point_edge_time_of_impact_2d.sv
